FILE: hw/rtl/gss_pkg.sv
// Shared types and constants of the Gray-Scott stencil step block.
// No dependencies; every other file of the block but gss_line_buf refers to it by scoped names.
package gss_pkg;

    // grid geometry
    localparam int GRID_WIDTH  = 160;
    localparam int GRID_HEIGHT = 120;

    // column runs 0..W-1, row runs 0..H+1 (tail of frame, then hold)
    localparam int COL_W = $clog2(GRID_WIDTH);
    localparam int ROW_W = $clog2(GRID_HEIGHT + 2);

    // Q12 cell values
    localparam int CELL_W     = 13;
    localparam int ONE_Q12    = 4096;
    localparam int FRAC_W     = 12;
    localparam int DIFF_SHIFT = 8;

    // arithmetic widths
    localparam int NSUM_W = CELL_W + 2;     // sum of four neighbors
    localparam int LAP_W  = CELL_W + 4;     // signed Laplacian
    localparam int SUM_W  = 20;             // signed next-value accumulator

    // configuration register widths and reset values
    localparam int DIFF_W = 8;
    localparam int RATE_W = 12;
    localparam logic [DIFF_W-1:0] DIFF_U_RST = 8'd54;
    localparam logic [DIFF_W-1:0] DIFF_V_RST = 8'd26;
    localparam logic [RATE_W-1:0] FEED_RST   = 12'd150;
    localparam logic [RATE_W-1:0] KILL_RST   = 12'd249;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_DIFF_U = 2'd0,
        REG_DIFF_V = 2'd1,
        REG_FEED   = 2'd2,
        REG_KILL   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CELL_W-1:0] u;
        logic [CELL_W-1:0] v;
    } t_cell;

    // stencil window of one emitted cell
    typedef struct packed {
        t_cell up;
        t_cell left;
        t_cell center;
        t_cell right;
        t_cell down;
        logic  border;
        logic  frame_end;
    } t_win;

    typedef struct packed {
        logic [DIFF_W-1:0] diff_u;
        logic [DIFF_W-1:0] diff_v;
        logic [RATE_W-1:0] feed;
        logic [RATE_W-1:0] kill;
    } t_cfg;

endpackage

FILE: hw/rtl/gss_line_buf.sv
// Line buffer: a RAM used as a fixed delay of DEPTH accepted beats.
// Read-before-write at one rotating address; read data is registered. No dependencies.
module gss_line_buf #(
    parameter int DEPTH = 160,
    parameter int WIDTH = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W-1:0] n_ptr;

    // rotating address
    always_comb begin
        if (r_ptr == PTR_W'(DEPTH - 1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_en) begin
            r_ptr <= n_ptr;
        end
    end

    // old entry comes out as the new one goes in
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata      <= r_mem[r_ptr];
            r_mem[r_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/gss_cfg.sv
// APB-style configuration registers: diffusion rates, feed and kill rates.
// Depends on gss_pkg.
module gss_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gss_pkg::PADDR_W-1:0]  paddr,
    input  logic [gss_pkg::PDATA_W-1:0]  pwdata,
    output logic [gss_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output gss_pkg::t_cfg                o_cfg
);

    gss_pkg::t_cfg    r_cfg;
    gss_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = gss_pkg::t_reg_idx'(paddr[gss_pkg::PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.diff_u <= gss_pkg::DIFF_U_RST;
            r_cfg.diff_v <= gss_pkg::DIFF_V_RST;
            r_cfg.feed   <= gss_pkg::FEED_RST;
            r_cfg.kill   <= gss_pkg::KILL_RST;
        end else if (w_wr) begin
            case (w_idx)
                gss_pkg::REG_DIFF_U: r_cfg.diff_u <= pwdata[gss_pkg::DIFF_W-1:0];
                gss_pkg::REG_DIFF_V: r_cfg.diff_v <= pwdata[gss_pkg::DIFF_W-1:0];
                gss_pkg::REG_FEED:   r_cfg.feed   <= pwdata[gss_pkg::RATE_W-1:0];
                gss_pkg::REG_KILL:   r_cfg.kill   <= pwdata[gss_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            gss_pkg::REG_DIFF_U: prdata = gss_pkg::PDATA_W'(r_cfg.diff_u);
            gss_pkg::REG_DIFF_V: prdata = gss_pkg::PDATA_W'(r_cfg.diff_v);
            gss_pkg::REG_FEED:   prdata = gss_pkg::PDATA_W'(r_cfg.feed);
            gss_pkg::REG_KILL:   prdata = gss_pkg::PDATA_W'(r_cfg.kill);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/gss_window.sv
// Raster position tracking, two line buffers and the stencil window stage.
// Depends on gss_pkg and gss_line_buf.
module gss_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [gss_pkg::CELL_W-1:0]  i_u,
    input  logic [gss_pkg::CELL_W-1:0]  i_v,
    input  logic                        i_frame_start,
    input  logic                        i_flush,
    input  logic                        i_dp_ready,
    output logic                        o_win_valid,
    output gss_pkg::t_win               o_win
);

    localparam int COL_W = gss_pkg::COL_W;
    localparam int ROW_W = gss_pkg::ROW_W;

    logic              w_en;
    logic              w_acc;
    gss_pkg::t_cell    w_x;
    gss_pkg::t_cell    w_right;
    gss_pkg::t_cell    w_up;
    gss_pkg::t_cell    r_down;
    gss_pkg::t_cell    r_center;
    gss_pkg::t_cell    r_left;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  w_col;
    logic [ROW_W-1:0]  w_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  w_cx;
    logic [ROW_W-1:0]  w_cy;
    logic              w_emit;
    logic              w_hold;

    logic              r_win_valid;
    gss_pkg::t_win     r_win;

    // window stage moves when empty or when the datapath takes it
    assign w_en    = !r_win_valid || i_dp_ready;
    assign o_ready = w_en;
    assign w_acc   = i_valid && w_en;

    // filler beats store zero
    assign w_x.u = i_flush ? '0 : i_u;
    assign w_x.v = i_flush ? '0 : i_v;

    // right tap: input delayed by W-1 beats
    gss_line_buf #(
        .DEPTH (gss_pkg::GRID_WIDTH - 1),
        .WIDTH (2 * gss_pkg::CELL_W)
    ) u_lb_near (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_acc),
        .i_wdata (w_x),
        .o_rdata (w_right)
    );

    // up tap: right tap delayed by W more beats
    gss_line_buf #(
        .DEPTH (gss_pkg::GRID_WIDTH),
        .WIDTH (2 * gss_pkg::CELL_W)
    ) u_lb_far (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_acc),
        .i_wdata (w_right),
        .o_rdata (w_up)
    );

    // short taps
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_down   <= w_x;
            r_center <= w_right;
            r_left   <= r_center;
        end
    end

    // position of this beat and of the cell it emits
    always_comb begin
        w_col = i_frame_start ? '0 : r_col;
        w_row = i_frame_start ? '0 : r_row;

        if (w_col == '0) begin
            w_cx = COL_W'(gss_pkg::GRID_WIDTH - 1);
            w_cy = w_row - ROW_W'(2);
        end else begin
            w_cx = w_col - COL_W'(1);
            w_cy = w_row - ROW_W'(1);
        end

        w_emit = (w_row >= ROW_W'(2) || (w_row == ROW_W'(1) && w_col != '0))
                 && (w_cy < ROW_W'(gss_pkg::GRID_HEIGHT));

        // past the frame tail the position holds
        w_hold = (w_row > ROW_W'(gss_pkg::GRID_HEIGHT)) && (w_col != '0);

        n_col = w_col;
        n_row = w_row;
        if (!w_hold) begin
            if (w_col == COL_W'(gss_pkg::GRID_WIDTH - 1)) begin
                n_col = '0;
                n_row = w_row + ROW_W'(1);
            end else begin
                n_col = w_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // window stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_valid <= 1'b0;
        end else if (w_en) begin
            r_win_valid <= w_acc && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_win.up        <= w_up;
            r_win.left      <= r_left;
            r_win.center    <= r_center;
            r_win.right     <= w_right;
            r_win.down      <= r_down;
            r_win.border    <= (w_cx == '0)
                            || (w_cx == COL_W'(gss_pkg::GRID_WIDTH - 1))
                            || (w_cy == '0)
                            || (w_cy == ROW_W'(gss_pkg::GRID_HEIGHT - 1));
            r_win.frame_end <= (w_cx == COL_W'(gss_pkg::GRID_WIDTH - 1))
                            && (w_cy == ROW_W'(gss_pkg::GRID_HEIGHT - 1));
        end
    end

    assign o_win_valid = r_win_valid;
    assign o_win       = r_win;

endmodule

FILE: hw/rtl/gss_datapath.sv
// Reaction-diffusion arithmetic: Laplacian and products, scaling, sum and clamp.
// Two register stages plus the output register. Depends on gss_pkg.
module gss_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_win_valid,
    input  gss_pkg::t_win               i_win,
    output logic                        o_ready,
    input  gss_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gss_pkg::CELL_W-1:0]  o_u,
    output logic [gss_pkg::CELL_W-1:0]  o_v,
    output logic                        o_frame_end
);

    localparam int CELL_W = gss_pkg::CELL_W;
    localparam int NSUM_W = gss_pkg::NSUM_W;
    localparam int LAP_W  = gss_pkg::LAP_W;
    localparam int SUM_W  = gss_pkg::SUM_W;
    localparam int FRAC_W = gss_pkg::FRAC_W;
    localparam int DSH    = gss_pkg::DIFF_SHIFT;
    localparam int RATE_W = gss_pkg::RATE_W;
    localparam int DIFF_W = gss_pkg::DIFF_W;

    localparam int PUV_W  = 2 * CELL_W;                 // U*V
    localparam int UVS_W  = PUV_W - FRAC_W;             // U*V >> 12
    localparam int UVV_W  = UVS_W + CELL_W;             // (U*V >> 12) * V
    localparam int OMU_W  = CELL_W + 1;                 // 4096 - U, signed
    localparam int PFU_W  = RATE_W + 1 + OMU_W;         // F * (4096 - U)
    localparam int FK_W   = RATE_W + 1;                 // F + K
    localparam int PFK_W  = FK_W + CELL_W;              // (F + K) * V
    localparam int PD_W   = DIFF_W + 1 + LAP_W;         // D * lap

    // clamp to 0..4096
    function automatic logic [CELL_W-1:0] clamp_q12(input logic signed [SUM_W-1:0] x);
        logic [CELL_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > SUM_W'(gss_pkg::ONE_Q12)) begin
            res = CELL_W'(gss_pkg::ONE_Q12);
        end else begin
            res = x[CELL_W-1:0];
        end
        return res;
    endfunction

    // stage handshake: each stage moves when empty or when the next one moves
    logic r_v2, r_v3, r_vo;
    logic w_rdy2, w_rdy3, w_rdyo;

    assign w_rdyo  = !r_vo || i_ready;
    assign w_rdy3  = !r_v3 || w_rdyo;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy2) r_v2 <= i_win_valid;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdyo) r_vo <= r_v3;
        end
    end

    // stage 2: Laplacians and first products
    logic [NSUM_W-1:0]       w_nsum_u, w_nsum_v;
    logic signed [OMU_W-1:0] w_omu;
    logic [FK_W-1:0]         w_fk;

    logic signed [LAP_W-1:0] r2_lap_u, r2_lap_v;
    logic [PUV_W-1:0]        r2_uv;
    logic signed [PFU_W-1:0] r2_fu;
    logic [PFK_W-1:0]        r2_fkv;
    gss_pkg::t_cell          r2_c;
    logic                    r2_border, r2_fe;

    assign w_nsum_u = NSUM_W'(i_win.up.u) + NSUM_W'(i_win.left.u)
                    + NSUM_W'(i_win.right.u) + NSUM_W'(i_win.down.u);
    assign w_nsum_v = NSUM_W'(i_win.up.v) + NSUM_W'(i_win.left.v)
                    + NSUM_W'(i_win.right.v) + NSUM_W'(i_win.down.v);
    assign w_omu    = OMU_W'(gss_pkg::ONE_Q12) - $signed({1'b0, i_win.center.u});
    assign w_fk     = FK_W'(i_cfg.feed) + FK_W'(i_cfg.kill);

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_lap_u  <= $signed({2'b00, w_nsum_u}) - $signed({2'b00, i_win.center.u, 2'b00});
            r2_lap_v  <= $signed({2'b00, w_nsum_v}) - $signed({2'b00, i_win.center.v, 2'b00});
            r2_uv     <= PUV_W'(i_win.center.u) * PUV_W'(i_win.center.v);
            r2_fu     <= $signed({1'b0, i_cfg.feed}) * w_omu;
            r2_fkv    <= PFK_W'(w_fk) * PFK_W'(i_win.center.v);
            r2_c      <= i_win.center;
            r2_border <= i_win.border;
            r2_fe     <= i_win.frame_end;
        end
    end

    // stage 3: diffusion products and the reaction product
    logic signed [PD_W-1:0]          r3_du, r3_dv;
    logic [UVV_W-1:0]                r3_uvv;
    logic signed [PFU_W-FRAC_W-1:0]  r3_fu;
    logic [PFK_W-FRAC_W-1:0]         r3_fkv;
    gss_pkg::t_cell                  r3_c;
    logic                            r3_border, r3_fe;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_du     <= $signed({1'b0, i_cfg.diff_u}) * r2_lap_u;
            r3_dv     <= $signed({1'b0, i_cfg.diff_v}) * r2_lap_v;
            r3_uvv    <= UVV_W'(r2_uv[PUV_W-1:FRAC_W]) * UVV_W'(r2_c.v);
            r3_fu     <= r2_fu[PFU_W-1:FRAC_W];        // floor shift
            r3_fkv    <= r2_fkv[PFK_W-1:FRAC_W];
            r3_c      <= r2_c;
            r3_border <= r2_border;
            r3_fe     <= r2_fe;
        end
    end

    // stage 4: sum, clamp, border bypass into the output register
    logic signed [PD_W-DSH-1:0]       w_du_t, w_dv_t;
    logic signed [UVV_W-FRAC_W:0]     w_uvv_t;
    logic signed [PFK_W-FRAC_W:0]     w_fkv_t;
    logic signed [CELL_W:0]           w_u_s, w_v_s;
    logic signed [SUM_W-1:0]          w_nu, w_nv;

    assign w_du_t  = r3_du[PD_W-1:DSH];
    assign w_dv_t  = r3_dv[PD_W-1:DSH];
    assign w_uvv_t = $signed({1'b0, r3_uvv[UVV_W-1:FRAC_W]});
    assign w_fkv_t = $signed({1'b0, r3_fkv});
    assign w_u_s   = $signed({1'b0, r3_c.u});
    assign w_v_s   = $signed({1'b0, r3_c.v});

    assign w_nu = SUM_W'(w_u_s) + SUM_W'(w_du_t) - SUM_W'(w_uvv_t) + SUM_W'(r3_fu);
    assign w_nv = SUM_W'(w_v_s) + SUM_W'(w_dv_t) + SUM_W'(w_uvv_t) - SUM_W'(w_fkv_t);

    logic [CELL_W-1:0] r_o_u, r_o_v;
    logic              r_o_fe;

    always_ff @(posedge i_clk) begin
        if (w_rdyo) begin
            r_o_u  <= r3_border ? r3_c.u : clamp_q12(w_nu);
            r_o_v  <= r3_border ? r3_c.v : clamp_q12(w_nv);
            r_o_fe <= r3_fe;
        end
    end

    assign o_valid     = r_vo;
    assign o_u         = r_o_u;
    assign o_v         = r_o_v;
    assign o_frame_end = r_o_fe;

endmodule

FILE: hw/rtl/gray_scott_stencil_step.sv
// Top level of the Gray-Scott stencil step: configuration, window and datapath.
// Depends on gss_pkg, gss_cfg, gss_window, gss_datapath and gss_line_buf.
//
// Usage:
//   The input channel takes the current u,v grid one cell per beat in raster
//   order; frame_start marks cell 0, and flush beats (no cell data) push out
//   the tail. Each input beat emits at most one result beat: the next value
//   of the cell one row plus one cell behind it, so a full frame needs
//   GRID_WIDTH+1 flush beats after its last cell, the last of which carries
//   frame_end. Border cells pass through; interior cells are clamped to 0..4096.
//   Throughput is one beat per cycle when the receiver does not stall: two line
//   buffers (one RAM port pair each) supply the stencil and the multipliers are
//   fully pipelined. Four register stages: window, stage 2, stage 3 and output.
//   Stalls: a full stage holds its data; ready on the input stays high while
//   any stage ahead is empty, so bubbles are squeezed out and nothing is lost.
//   Reset clears the position (acts as a frame start), the stage valids and
//   the registers to their defaults; line buffer contents start unknown.
//   Registers must be written through the APB port only while the block is
//   idle; the block itself does not enforce this.
module gray_scott_stencil_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gss_pkg::PADDR_W-1:0] paddr,
    input  logic [gss_pkg::PDATA_W-1:0] pwdata,
    output logic [gss_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // input cells
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [gss_pkg::CELL_W-1:0]  i_u_cell,
    input  logic [gss_pkg::CELL_W-1:0]  i_v_cell,
    input  logic                        i_frame_start,
    input  logic                        i_flush,
    // results
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [gss_pkg::CELL_W-1:0]  o_u_next,
    output logic [gss_pkg::CELL_W-1:0]  o_v_next,
    output logic                        o_frame_end
);

    gss_pkg::t_cfg w_cfg;
    gss_pkg::t_win w_win;
    logic          w_win_valid;
    logic          w_dp_ready;

    gss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    gss_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_u           (i_u_cell),
        .i_v           (i_v_cell),
        .i_frame_start (i_frame_start),
        .i_flush       (i_flush),
        .i_dp_ready    (w_dp_ready),
        .o_win_valid   (w_win_valid),
        .o_win         (w_win)
    );

    gss_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (w_win_valid),
        .i_win       (w_win),
        .o_ready     (w_dp_ready),
        .i_cfg       (w_cfg),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_u         (o_u_next),
        .o_v         (o_v_next),
        .o_frame_end (o_frame_end)
    );

endmodule

FILE: tb/sv/tb_gray_scott_stencil_step.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Gray-Scott stencil step: a table of directed runs,
// then random phases, checked against a stencil predictor kept here.
// Depends on gss_pkg and gray_scott_stencil_step.
module tb_gray_scott_stencil_step;

    localparam int GRID_WIDTH  = gss_pkg::GRID_WIDTH;
    localparam int GRID_HEIGHT = gss_pkg::GRID_HEIGHT;
    localparam int CELL_W      = gss_pkg::CELL_W;
    localparam int ONE_Q12     = gss_pkg::ONE_Q12;
    localparam int DIFF_W      = gss_pkg::DIFF_W;
    localparam int RATE_W      = gss_pkg::RATE_W;
    localparam int PADDR_W     = gss_pkg::PADDR_W;
    localparam int PDATA_W     = gss_pkg::PDATA_W;
    localparam int DEPTH       = 2 * GRID_WIDTH + 2;

    typedef enum logic [1:0] {
        FILL_FIXED,
        FILL_EXTREME,
        FILL_RANDOM,
        FILL_OVER
    } t_fill;

    // one run of identical-kind input beats in the directed table
    typedef struct packed {
        int                count;
        t_fill             fill;
        logic [CELL_W-1:0] u;
        logic [CELL_W-1:0] v;
        logic              fs;
        logic              flush;
        logic              known;
        logic              end_last;
        logic [CELL_W-1:0] eu;
        logic [CELL_W-1:0] ev;
    } t_run;

    typedef struct packed {
        logic [CELL_W-1:0] u;
        logic [CELL_W-1:0] v;
        logic              fs;
        logic              flush;
    } t_cell_beat;

    typedef struct packed {
        logic [CELL_W-1:0] u_next;
        logic [CELL_W-1:0] v_next;
        logic              frame_end;
    } t_next_cell;

    // directed runs; known rows carry the result that every beat they cause must show
    localparam t_run DIR_RUNS [8] = '{
        // reset acts as a frame start; uniform u=1, v=0 on the top border passes through
        '{165,   FILL_FIXED,   13'd4096, 13'd0,    1'b0, 1'b0, 1'b1, 1'b0, 13'd4096, 13'd0},
        // frame start in mid-frame abandons the old frame
        '{1,     FILL_FIXED,   13'd4096, 13'd0,    1'b1, 1'b0, 1'b0, 1'b0, 13'd0,    13'd0},
        '{38,    FILL_FIXED,   13'd4096, 13'd0,    1'b0, 1'b0, 1'b0, 1'b0, 13'd0,    13'd0},
        // out-of-range cells: they fall on the top border and pass through
        '{20,    FILL_OVER,    13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 1'b0, 13'd0,    13'd0},
        '{10,    FILL_FIXED,   13'd8191, 13'd8191, 1'b0, 1'b0, 1'b0, 1'b0, 13'd0,    13'd0},
        '{30,    FILL_EXTREME, 13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 1'b0, 13'd0,    13'd0},
        // filler beats in mid-frame store zeros
        '{10,    FILL_RANDOM,  13'd0,    13'd0,    1'b0, 1'b1, 1'b0, 1'b0, 13'd0,    13'd0},
        '{200,   FILL_RANDOM,  13'd0,    13'd0,    1'b0, 1'b0, 1'b0, 1'b0, 13'd0,    13'd0}
    };

    // DUT ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CELL_W-1:0]   u_cell = '0;
    logic [CELL_W-1:0]   v_cell = '0;
    logic                frame_start = 1'b0;
    logic                flush_bit = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CELL_W-1:0]   u_next;
    logic [CELL_W-1:0]   v_next;
    logic                frame_end;

    // predictor state
    logic [CELL_W-1:0]   u_line [DEPTH];
    logic [CELL_W-1:0]   v_line [DEPTH];
    int                  wr_slot = 0;
    int                  col_pos = 0;
    int                  row_pos = 0;
    logic [DIFF_W-1:0]   cfg_du = 8'd54;
    logic [DIFF_W-1:0]   cfg_dv = 8'd26;
    logic [RATE_W-1:0]   cfg_feed = 12'd150;
    logic [RATE_W-1:0]   cfg_kill = 12'd249;

    t_next_cell          next_cell_q [$];
    int                  errors = 0;
    int                  send_idle = 37;
    int                  recv_idle = 80;
    int                  prev_u = 2048;
    int                  prev_v = 2048;

    gray_scott_stencil_step i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_u_cell      (u_cell),
        .i_v_cell      (v_cell),
        .i_frame_start (frame_start),
        .i_flush       (flush_bit),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_u_next      (u_next),
        .o_v_next      (v_next),
        .o_frame_end   (frame_end)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // line buffer slot of the cell k beats behind the write slot
    function automatic int slot_back(input int k);
        int t;
        t = wr_slot + DEPTH - k;
        return (t >= DEPTH) ? t - DEPTH : t;
    endfunction

    // advance the stencil by one input beat; returns 1 when a cell comes out
    function automatic bit advance_stencil(input t_cell_beat b, output t_next_cell r);
        bit     emit;
        int     cx, cy, c, l, rt, a, d;
        longint cu, cv, lu, lv, uvv, nu, nv;
        if (b.fs) begin
            col_pos = 0;
            row_pos = 0;
            wr_slot = 0;
        end
        u_line[wr_slot] = b.flush ? '0 : b.u;
        v_line[wr_slot] = b.flush ? '0 : b.v;

        cx = 0;
        cy = 0;
        emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
        if (emit) begin
            if (col_pos == 0) begin
                cx = GRID_WIDTH - 1;
                cy = row_pos - 2;
            end else begin
                cx = col_pos - 1;
                cy = row_pos - 1;
            end
            emit = (cy < GRID_HEIGHT);
        end

        r = '0;
        if (emit) begin
            c  = slot_back(GRID_WIDTH + 1);
            cu = longint'(u_line[c]);
            cv = longint'(v_line[c]);
            nu = cu;
            nv = cv;
            if (cx != 0 && cx != GRID_WIDTH - 1 && cy != 0 && cy != GRID_HEIGHT - 1) begin
                l  = slot_back(GRID_WIDTH + 2);
                rt = slot_back(GRID_WIDTH);
                a  = slot_back(2 * GRID_WIDTH + 1);
                d  = slot_back(1);
                lu = longint'(u_line[l]) + longint'(u_line[rt]) + longint'(u_line[a])
                   + longint'(u_line[d]) - 4 * cu;
                lv = longint'(v_line[l]) + longint'(v_line[rt]) + longint'(v_line[a])
                   + longint'(v_line[d]) - 4 * cv;
                // arithmetic shifts of signed values floor
                uvv = (((cu * cv) >>> 12) * cv) >>> 12;
                nu = cu + ((longint'(cfg_du) * lu) >>> 8) - uvv
                   + ((longint'(cfg_feed) * (ONE_Q12 - cu)) >>> 12);
                nv = cv + ((longint'(cfg_dv) * lv) >>> 8) + uvv
                   - (((longint'(cfg_feed) + longint'(cfg_kill)) * cv) >>> 12);
                if (nu < 0) nu = 0;
                if (nu > ONE_Q12) nu = ONE_Q12;
                if (nv < 0) nv = 0;
                if (nv > ONE_Q12) nv = ONE_Q12;
            end
            r.u_next    = nu[CELL_W-1:0];
            r.v_next    = nv[CELL_W-1:0];
            r.frame_end = (cx == GRID_WIDTH - 1 && cy == GRID_HEIGHT - 1);
        end

        wr_slot = (wr_slot + 1 == DEPTH) ? 0 : wr_slot + 1;
        // position holds once the tail is out
        if (!(row_pos > GRID_HEIGHT && col_pos >= 1)) begin
            col_pos++;
            if (col_pos >= GRID_WIDTH) begin
                col_pos = 0;
                row_pos++;
            end
        end
        return emit;
    endfunction

    // mix of extremes, smooth runs, uniform and out-of-range values
    function automatic logic [CELL_W-1:0] pick_value(inout int prev);
        int r;
        r = $urandom_range(99);
        if (r < 10)
            prev = 0;
        else if (r < 20)
            prev = ONE_Q12;
        else if (r < 25)
            return CELL_W'($urandom_range(8191, 4097));
        else if (r < 60) begin
            prev = prev + $urandom_range(128) - 64;
            if (prev < 0) prev = 0;
            if (prev > ONE_Q12) prev = ONE_Q12;
        end else
            prev = $urandom_range(ONE_Q12);
        return CELL_W'(prev);
    endfunction

    // result monitor
    always @(posedge clk) begin
        t_next_cell want;
        if (rst_n && out_valid && out_ready) begin
            if (next_cell_q.size() == 0) begin
                errors++;
                $error("result beat with nothing expected: u_next %0d v_next %0d",
                       u_next, v_next);
            end else begin
                want = next_cell_q.pop_front();
                check_field("u_next", 32'(want.u_next), 32'(u_next));
                check_field("v_next", 32'(want.v_next), 32'(v_next));
                check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
            end
        end
    end

    // one input beat: random gap, then hold until accepted, then predict
    task automatic send_beat(input t_cell_beat b, input bit known, input t_next_cell typed);
        t_next_cell r;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        u_cell      <= b.u;
        v_cell      <= b.v;
        frame_start <= b.fs;
        flush_bit   <= b.flush;
        do @(posedge clk); while (!in_ready);
        if (advance_stencil(b, r))
            next_cell_q.push_back(known ? typed : r);
    endtask

    task automatic send_random(input logic fs, input logic fl);
        t_cell_beat b;
        b.u     = pick_value(prev_u);
        b.v     = pick_value(prev_v);
        b.fs    = fs;
        b.flush = fl;
        send_beat(b, 1'b0, '0);
    endtask

    // stop sending, wait for every result, then let the pipeline settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (next_cell_q.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic apb_write(input gss_pkg::t_reg_idx idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field("pready", 32'd1, 32'(pready));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input gss_pkg::t_reg_idx idx, output logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        logic [PDATA_W-1:0] rd;
        apb_read(gss_pkg::REG_DIFF_U, rd);
        check_field("diffusion_u", 32'(cfg_du), 32'(rd[DIFF_W-1:0]));
        apb_read(gss_pkg::REG_DIFF_V, rd);
        check_field("diffusion_v", 32'(cfg_dv), 32'(rd[DIFF_W-1:0]));
        apb_read(gss_pkg::REG_FEED, rd);
        check_field("feed_rate", 32'(cfg_feed), 32'(rd[RATE_W-1:0]));
        apb_read(gss_pkg::REG_KILL, rd);
        check_field("kill_rate", 32'(cfg_kill), 32'(rd[RATE_W-1:0]));
    endtask

    task automatic set_config(input logic [DIFF_W-1:0] du, input logic [DIFF_W-1:0] dv,
                              input logic [RATE_W-1:0] fd, input logic [RATE_W-1:0] kl);
        apb_write(gss_pkg::REG_DIFF_U, PDATA_W'(du));
        apb_write(gss_pkg::REG_DIFF_V, PDATA_W'(dv));
        apb_write(gss_pkg::REG_FEED, PDATA_W'(fd));
        apb_write(gss_pkg::REG_KILL, PDATA_W'(kl));
        cfg_du   = du;
        cfg_dv   = dv;
        cfg_feed = fd;
        cfg_kill = kl;
        check_regs();
    endtask

    // random cells with occasional filler beats, continuing the current frame
    task automatic run_random_phase(input int count, input int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n == pause_at)
                drain_results();
            send_random(1'b0, ($urandom_range(99) < 10));
        end
    endtask

    initial begin
        t_run       run;
        t_cell_beat b;
        t_next_cell typed;

        for (int i = 0; i < DEPTH; i++) begin
            u_line[i] = '0;
            v_line[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_regs();

        // directed runs at reset settings
        for (int i = 0; i < $size(DIR_RUNS); i++) begin
            run = DIR_RUNS[i];
            for (int n = 0; n < run.count; n++) begin
                case (run.fill)
                    FILL_FIXED: begin
                        b.u = run.u;
                        b.v = run.v;
                    end
                    FILL_EXTREME: begin
                        b.u = $urandom_range(1) ? 13'd4096 : 13'd0;
                        b.v = $urandom_range(1) ? 13'd4096 : 13'd0;
                    end
                    FILL_OVER: begin
                        b.u = CELL_W'($urandom_range(8191, 4097));
                        b.v = CELL_W'($urandom_range(8191, 4097));
                    end
                    default: begin
                        b.u = pick_value(prev_u);
                        b.v = pick_value(prev_v);
                    end
                endcase
                b.fs            = run.fs && (n == 0);
                b.flush         = run.flush;
                typed.u_next    = run.eu;
                typed.v_next    = run.ev;
                typed.frame_end = run.end_last && (n == run.count - 1);
                send_beat(b, run.known, typed);
            end
        end
        drain_results();

        // sender idles less than receiver, strongest settings, one full pause
        set_config(8'd255, 8'd255, 12'd4095, 12'd4095);
        run_random_phase(25, 12);
        drain_results();

        // receiver idles less than sender, all rates zero
        send_idle = 80;
        recv_idle = 37;
        set_config(8'd0, 8'd0, 12'd0, 12'd0);
        run_random_phase(25, -1);
        drain_results();

        // no idling, random settings
        send_idle = 0;
        recv_idle = 0;
        set_config(DIFF_W'($urandom_range(255)), DIFF_W'($urandom_range(255)),
                   RATE_W'($urandom_range(4095)), RATE_W'($urandom_range(4095)));
        run_random_phase(25, -1);
        drain_results();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // run limit
    initial begin
        #(2_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
